@@ rtl/plen_pkg.sv @@
// ----------------------------------------------------------------------------
// plen_pkg
// shared types and constants of the positional list engine
// ----------------------------------------------------------------------------
package plen_pkg;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_END   = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_FIRST = 3'd3,
        ACT_DEL_LAST  = 3'd4,
        ACT_DEL_POS   = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the request on an input transfer
        logic exec;   // run the request and write the result register
    } ctrl_cmd_t;

endpackage

@@ rtl/plen_req_if.sv @@
// ----------------------------------------------------------------------------
// plen_req_if
// request channel: action, value and position with valid/ready
// ----------------------------------------------------------------------------
interface plen_req_if;

    logic                                valid;
    logic                                ready;
    logic        [plen_pkg::ACTION_W-1:0] action;
    logic signed [plen_pkg::VALUE_W-1:0]  value;
    logic        [plen_pkg::POS_W-1:0]    position;

    modport source (output valid, output action, output value, output position, input ready);
    modport sink   (input valid, input action, input value, input position, output ready);

endinterface

@@ rtl/plen_rsp_if.sv @@
// ----------------------------------------------------------------------------
// plen_rsp_if
// result channel: status, removed value and count with valid/ready
// ----------------------------------------------------------------------------
interface plen_rsp_if;

    logic                                 valid;
    logic                                 ready;
    logic        [plen_pkg::STATUS_W-1:0] status;
    logic signed [plen_pkg::VALUE_W-1:0]  removed_value;
    logic                                 removed_valid;
    logic        [plen_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output removed_value,
                    output removed_valid, output entry_count, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input removed_valid, input entry_count, output ready);

endinterface

@@ rtl/plen_ctrl.sv @@
// ----------------------------------------------------------------------------
// plen_ctrl
// request sequencer: takes one request, runs it, holds the result valid
// ----------------------------------------------------------------------------
module plen_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output plen_pkg::ctrl_cmd_t cmd
);
    import plen_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.load = (state_reg == S_IDLE) && in_valid && in_ready_reg;
        cmd.exec = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        // result taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready_next = 1'b1;
                if (cmd.load)
                begin
                    state_next    = S_EXEC;
                    in_ready_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next     = S_IDLE;
                    in_ready_next  = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/plen_dpath.sv @@
// ----------------------------------------------------------------------------
// plen_dpath
// list storage with parallel one-slot shift, request and result registers
// ----------------------------------------------------------------------------
module plen_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  plen_pkg::ctrl_cmd_t                 cmd,
    input  logic        [plen_pkg::ACTION_W-1:0] action,
    input  logic signed [plen_pkg::VALUE_W-1:0]  value,
    input  logic        [plen_pkg::POS_W-1:0]    position,
    output logic        [plen_pkg::STATUS_W-1:0] status,
    output logic signed [plen_pkg::VALUE_W-1:0]  removed_value,
    output logic                                removed_valid,
    output logic        [plen_pkg::COUNT_W-1:0]  entry_count,
    output logic        [$clog2(DEPTH+1)-1:0]    count
);
    import plen_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    // captured request
    logic [ACTION_W-1:0] action_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [POS_W-1:0]    position_reg;

    logic [VALUE_W-1:0]  entries_reg [DEPTH];
    logic [VALUE_W-1:0]  entries_next [DEPTH];
    logic [CW-1:0]       count_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [VALUE_W-1:0]  removed_value_reg;
    logic                removed_valid_reg;
    logic [COUNT_W-1:0]  entry_count_reg;

    logic [CMPW-1:0] cnt_w, pos_w, slot_k, cnt_new;
    logic            full, empty, do_ins, do_del;
    status_t         st;

    always_comb
    begin
        cnt_w  = CMPW'(count_reg);
        pos_w  = CMPW'(position_reg);
        full   = (cnt_w == CMPW'(DEPTH));
        empty  = (cnt_w == '0);
        do_ins = 1'b0;
        do_del = 1'b0;
        slot_k = '0;
        st     = ST_DONE;
        case (action_t'(action_reg))
            ACT_INS_FRONT:
            begin
                if (full) st = ST_FULL;
                else do_ins = 1'b1;
            end
            ACT_INS_END:
            begin
                slot_k = cnt_w;
                if (full) st = ST_FULL;
                else do_ins = 1'b1;
            end
            ACT_INS_POS:
            begin
                slot_k = pos_w - 1'b1;
                if (empty) st = ST_EMPTY;
                else if (pos_w == '0 || pos_w > cnt_w + 1'b1) st = ST_BADPOS;
                else if (full) st = ST_FULL;
                else do_ins = 1'b1;
            end
            ACT_DEL_FIRST:
            begin
                if (empty) st = ST_EMPTY;
                else do_del = 1'b1;
            end
            ACT_DEL_LAST:
            begin
                slot_k = cnt_w - 1'b1;
                if (empty) st = ST_EMPTY;
                else do_del = 1'b1;
            end
            ACT_DEL_POS:
            begin
                slot_k = pos_w - 1'b1;
                if (empty) st = ST_EMPTY;
                else if (pos_w == '0 || pos_w > cnt_w) st = ST_BADPOS;
                else do_del = 1'b1;
            end
            default:
            begin
                st = ST_BADPOS;
            end
        endcase
        cnt_new = do_ins ? cnt_w + 1'b1 : (do_del ? cnt_w - 1'b1 : cnt_w);
    end

    // every slot picks its neighbor, the new value or itself
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (do_ins)
            begin
                if (CMPW'(i) == slot_k)
                    entries_next[i] = value_reg;
                else if (i > 0 && CMPW'(i) > slot_k)
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
            end
            else if (do_del)
            begin
                if (i < DEPTH - 1 && CMPW'(i) >= slot_k)
                    entries_next[i] = entries_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg   <= action;
            value_reg    <= value;
            position_reg <= position;
        end
        if (cmd.exec)
        begin
            if (do_ins || do_del)
                entries_reg <= entries_next;
            status_reg        <= st;
            removed_valid_reg <= do_del;
            removed_value_reg <= do_del ? entries_reg[slot_k[IW-1:0]] : '0;
            entry_count_reg   <= cnt_new[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= cnt_new[CW-1:0];
    end

    assign status        = status_reg;
    assign removed_value = removed_value_reg;
    assign removed_valid = removed_valid_reg;
    assign entry_count   = entry_count_reg;
    assign count         = count_reg;

endmodule

@@ rtl/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed 32-bit values with positional insert and delete
// ----------------------------------------------------------------------------
// usage:
//   req carries one request per transfer: action (insert front, insert end,
//   insert at 1-based position, delete first, delete last, delete at
//   position), the value to insert and the position
//   rsp returns one result per request: status, removed value and flag,
//   and the element count after the request
//   sequence: a taken request moves the controller to the run state; the
//   run writes the result register and sets rsp.valid
//   overlap: a request waits until the last has run, set by the controller's
//   take / run sequence; the storage shifts all slots by one in parallel
//   stall: the result register holds while rsp.ready is low; one further
//   request may be taken and then waits in the run state until the
//   result register frees up
//   reset: the list is empty, no result is pending, req.ready is low in
//   the first cycle after reset; storage contents are not cleared, only
//   slots below the count are ever read
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int DEPTH = 16
) (
    input logic       clk,
    input logic       rst_n,
    plen_req_if.sink  req,
    plen_rsp_if.source rsp
);
    import plen_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    ctrl_cmd_t     cmd;
    logic [CW-1:0] count;

    // sequencer: handshakes and command timing
    plen_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // storage, decode and result register
    plen_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (req.action),
        .value         (req.value),
        .position      (req.position),
        .status        (rsp.status),
        .removed_value (rsp.removed_value),
        .removed_valid (rsp.removed_valid),
        .entry_count   (rsp.entry_count),
        .count         (count)
    );

    // count never passes the list depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(DEPTH))
        else $error("list count above depth");

    // a request transfer closes the input until the request has run
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("second request taken before the first ran");

    // a run always leaves a result pending
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> rsp.valid)
        else $error("run without a result");

    // a removed element only comes with a done status
    a_removed_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.removed_valid |-> rsp.status == ST_DONE)
        else $error("removed element with failure status");

endmodule
